// ===== rtl/core/segment_intersection_core_defines.svh =====
// ----------------------------------------------------------------------------
// segment_intersection_core_defines
// Assertion macros used by the segment intersection core.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/si_pkg.sv =====
// ----------------------------------------------------------------------------
// si_pkg
// Shared constants for the segment intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package si_pkg;
    localparam int FIELD_BITS = 16;
    localparam int OUT_BITS   = 32;
    localparam int CP_BITS    = 2 * FIELD_BITS + 4;
    localparam int NUM_BITS   = CP_BITS + FIELD_BITS + 2;
    localparam int DEN_BITS   = CP_BITS + 1;
endpackage

// ===== rtl/core/si_if.sv =====
// ----------------------------------------------------------------------------
// si_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface si_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/segment_intersection_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_core
// Proper-crossing test and fixed-point crossing point of two segments.
// ----------------------------------------------------------------------------
// Input channel i_seg carries one word of eight signed coordinates, packed
// {b_end_y, b_end_x, b_start_y, b_start_x, a_end_y, a_end_x, a_start_y,
// a_start_x}; output channel o_hit carries {hit, cross_y, cross_x}.
// Both channels are valid/ready; a word moves when both are high.
// Throughput: one word per cycle, back to back, while the output is not stalled.
// The pipeline at the default sizes has 3 front stages (differences,
// cross products, products), one stage per cell of each division chain
// (one cell per bit of the 54-bit product plus FRAC_BITS, so 70 cells),
// and one output stage.
// The whole pipeline advances together: when the receiver stalls and the
// output register is full, every stage holds and i_seg.ready drops in the
// same cycle; up to 74 words wait inside.
// Reset clears all valid bits; payload registers are not reset.
// A non-hit word outputs hit = 0 and zero coordinates.
`timescale 1ns / 1ps
`include "segment_intersection_core_defines.svh"
module segment_intersection_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    si_if.sink     i_seg,
    si_if.source   o_hit
);
    localparam int FB  = si_pkg::FIELD_BITS;
    localparam int CW  = (COORD_BITS < FB) ? COORD_BITS : FB;
    localparam int CPW = si_pkg::CP_BITS;
    localparam int NW  = si_pkg::NUM_BITS;
    localparam int DW  = si_pkg::DEN_BITS;
    localparam int QW  = NW + FRAC_BITS + 1;   // quotient bits
    localparam int NS  = NW + FRAC_BITS;       // cells in each chain
    localparam int OW  = si_pkg::OUT_BITS;
    localparam int SW  = FB + FRAC_BITS + 2;

    // Advance everything when the output register can take a word.
    logic adv;
    logic r_ovld;
    assign adv         = !r_ovld || o_hit.ready;
    assign i_seg.ready = adv;

    // Extract and sign-extend the coordinates.
    logic signed [FB:0] c [8];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c[k] = (FB+1)'($signed(i_seg.data[k*FB +: CW]));
        end
    end

    // Stage 1: differences.
    logic               r1_v;
    logic signed [FB+1:0] r1_bdx, r1_bdy, r1_adx, r1_ady;
    logic signed [FB+1:0] r1_e1x, r1_e1y, r1_e2x, r1_e2y;
    logic signed [FB+1:0] r1_f1x, r1_f1y, r1_f2x, r1_f2y;
    logic signed [FB:0]   r1_ax, r1_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (adv) r1_v <= i_seg.valid;
        if (adv) begin
            r1_bdx <= (FB+2)'(c[6]) - (FB+2)'(c[4]);
            r1_bdy <= (FB+2)'(c[7]) - (FB+2)'(c[5]);
            r1_adx <= (FB+2)'(c[2]) - (FB+2)'(c[0]);
            r1_ady <= (FB+2)'(c[3]) - (FB+2)'(c[1]);
            r1_e1x <= (FB+2)'(c[0]) - (FB+2)'(c[4]);
            r1_e1y <= (FB+2)'(c[1]) - (FB+2)'(c[5]);
            r1_e2x <= (FB+2)'(c[2]) - (FB+2)'(c[4]);
            r1_e2y <= (FB+2)'(c[3]) - (FB+2)'(c[5]);
            r1_f1x <= (FB+2)'(c[4]) - (FB+2)'(c[0]);
            r1_f1y <= (FB+2)'(c[5]) - (FB+2)'(c[1]);
            r1_f2x <= (FB+2)'(c[6]) - (FB+2)'(c[0]);
            r1_f2y <= (FB+2)'(c[7]) - (FB+2)'(c[1]);
            r1_ax  <= c[0];
            r1_ay  <= c[1];
        end
    end

    // Stage 2: cross products.
    logic                r2_v;
    logic signed [CPW-1:0] r2_d1, r2_d2, r2_d3, r2_d4;
    logic signed [FB+1:0]  r2_adx, r2_ady;
    logic signed [FB:0]    r2_ax, r2_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (adv) r2_v <= r1_v;
        if (adv) begin
            r2_d1 <= CPW'(r1_bdx * r1_e1y) - CPW'(r1_bdy * r1_e1x);
            r2_d2 <= CPW'(r1_bdx * r1_e2y) - CPW'(r1_bdy * r1_e2x);
            r2_d3 <= CPW'(r1_adx * r1_f1y) - CPW'(r1_ady * r1_f1x);
            r2_d4 <= CPW'(r1_adx * r1_f2y) - CPW'(r1_ady * r1_f2x);
            r2_adx <= r1_adx;
            r2_ady <= r1_ady;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
        end
    end

    // Stage 3: hit test, magnitudes and numerator products.
    logic n_hit, n_neg1, n_neg2;
    logic signed [DW-1:0] n_den;
    logic [CPW-1:0] n_m1;
    logic [FB+1:0]  n_mx, n_my;
    always_comb begin
        n_hit = (((r2_d1 > 0) && (r2_d2 < 0)) || ((r2_d1 < 0) && (r2_d2 > 0))) &&
                (((r2_d3 > 0) && (r2_d4 < 0)) || ((r2_d3 < 0) && (r2_d4 > 0)));
        n_den = DW'(r2_d1) - DW'(r2_d2);
        n_m1  = r2_d1[CPW-1] ? CPW'(-r2_d1) : CPW'(r2_d1);
        n_mx  = r2_adx[FB+1] ? (FB+2)'(-r2_adx) : (FB+2)'(r2_adx);
        n_my  = r2_ady[FB+1] ? (FB+2)'(-r2_ady) : (FB+2)'(r2_ady);
        // d1 and den share a sign on a hit, so only delta sets the sign.
        n_neg1 = r2_adx[FB+1];
        n_neg2 = r2_ady[FB+1];
    end

    logic          r3_v, r3_hit;
    logic [NW-1:0] r3_px, r3_py;
    logic [DW-1:0] r3_den;
    logic [SW-1:0] r3_sx, r3_sy;
    logic          r3_nx, r3_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (adv) r3_v <= r2_v;
        if (adv) begin
            r3_hit <= n_hit;
            r3_px  <= NW'(n_m1) * NW'(n_mx);
            r3_py  <= NW'(n_m1) * NW'(n_my);
            r3_den <= n_den[DW-1] ? DW'(-n_den) : DW'(n_den);
            r3_sx  <= SW'(r2_ax) <<< FRAC_BITS;
            r3_sy  <= SW'(r2_ay) <<< FRAC_BITS;
            r3_nx  <= n_neg1;
            r3_ny  <= n_neg2;
        end
    end

    // Division chains: numerator extended with FRAC_BITS zero bits.
    localparam int EW = NW + FRAC_BITS;
    logic [EW-1:0] ch_nx [NS+1];
    logic [EW-1:0] ch_ny [NS+1];
    logic [DW:0]   ch_rx [NS+1];
    logic [DW:0]   ch_ry [NS+1];
    logic [DW-1:0] ch_dx [NS+1];
    logic [DW-1:0] ch_dy [NS+1];
    logic [QW-1:0] ch_qx [NS+1];
    logic [QW-1:0] ch_qy [NS+1];
    logic [SW+3:0] sb    [NS+1];
    logic          sv    [NS+1];

    assign ch_nx[0] = EW'(r3_px) << FRAC_BITS;
    assign ch_ny[0] = EW'(r3_py) << FRAC_BITS;
    assign ch_rx[0] = '0;
    assign ch_ry[0] = '0;
    assign ch_dx[0] = r3_den;
    assign ch_dy[0] = r3_den;
    assign ch_qx[0] = '0;
    assign ch_qy[0] = '0;
    assign sb[0]    = {r3_hit, r3_nx, r3_ny, 1'b0, r3_sx};
    assign sv[0]    = r3_v;

    logic [SW-1:0] s_sy [NS+1];
    assign s_sy[0] = r3_sy;

    for (genvar g = 0; g < NS; g++) begin : g_chain
        si_div_cell #(.NUM_W(EW), .DEN_W(DW), .Q_W(QW)) u_cx (
            .i_clk(i_clk), .i_en(adv),
            .i_num(ch_nx[g]), .i_rem(ch_rx[g]), .i_den(ch_dx[g]), .i_quo(ch_qx[g]),
            .o_num(ch_nx[g+1]), .o_rem(ch_rx[g+1]), .o_den(ch_dx[g+1]),
            .o_quo(ch_qx[g+1])
        );
        si_div_cell #(.NUM_W(EW), .DEN_W(DW), .Q_W(QW)) u_cy (
            .i_clk(i_clk), .i_en(adv),
            .i_num(ch_ny[g]), .i_rem(ch_ry[g]), .i_den(ch_dy[g]), .i_quo(ch_qy[g]),
            .o_num(ch_ny[g+1]), .o_rem(ch_ry[g+1]), .o_den(ch_dy[g+1]),
            .o_quo(ch_qy[g+1])
        );
        logic [SW+3:0] r_sb;
        logic [SW-1:0] r_sy;
        logic          r_sv;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv <= 1'b0;
            else if (adv) r_sv <= sv[g];
            if (adv) begin
                r_sb <= sb[g];
                r_sy <= s_sy[g];
            end
        end
        assign sb[g+1]   = r_sb;
        assign s_sy[g+1] = r_sy;
        assign sv[g+1]   = r_sv;
    end

    // Final add and saturate.
    localparam int TW = (QW > SW ? QW : SW) + 2;
    localparam logic signed [TW-1:0] SAT_HI = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_LO = TW'(-64'sd2147483648);
    logic signed [TW-1:0] n_vx, n_vy;
    logic [OW-1:0] n_ox, n_oy;
    logic t_hit, t_nx, t_ny;
    logic [SW-1:0] t_sx;
    always_comb begin
        t_hit = sb[NS][SW+3];
        t_nx  = sb[NS][SW+2];
        t_ny  = sb[NS][SW+1];
        t_sx  = sb[NS][SW-1:0];
        n_vx  = TW'($signed(t_sx)) + (t_nx ? -TW'(ch_qx[NS]) : TW'(ch_qx[NS]));
        n_vy  = TW'($signed(s_sy[NS])) + (t_ny ? -TW'(ch_qy[NS]) : TW'(ch_qy[NS]));
        if (n_vx > SAT_HI)      n_ox = 32'h7FFF_FFFF;
        else if (n_vx < SAT_LO) n_ox = 32'h8000_0000;
        else                    n_ox = OW'(n_vx);
        if (n_vy > SAT_HI)      n_oy = 32'h7FFF_FFFF;
        else if (n_vy < SAT_LO) n_oy = 32'h8000_0000;
        else                    n_oy = OW'(n_vy);
        if (!t_hit) begin
            n_ox = '0;
            n_oy = '0;
        end
    end

    logic [2*OW:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (adv) r_ovld <= sv[NS];
        if (adv) r_odata <= {t_hit, n_oy, n_ox};
    end
    assign o_hit.valid = r_ovld;
    assign o_hit.data  = r_odata;

    `SI_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ovld && !o_hit.ready, r_ovld && $stable(r_odata), "output word changed while stalled")
    `SI_ASSERT_IMP(a_ready, i_clk, i_rst_n, !r_ovld, i_seg.ready, "not ready with empty output")
    `SI_ASSERT_IMP(a_zero, i_clk, i_rst_n, r_ovld && !r_odata[2*OW], r_odata[2*OW-1:0] == '0, "miss word carries coordinates")
endmodule

// ===== rtl/core/si_div_cell.sv =====
// ----------------------------------------------------------------------------
// si_div_cell
// One restoring-division cell: produce one quotient bit, pass on the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module si_div_cell #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W:0]   i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [Q_W-1:0]   i_quo,
    output logic [NUM_W-1:0] o_num,
    output logic [DEN_W:0]   o_rem,
    output logic [DEN_W-1:0] o_den,
    output logic [Q_W-1:0]   o_quo
);
    logic [DEN_W+1:0] n_shift;
    logic             n_ge;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quo;

    always_comb begin
        n_shift = {i_rem, i_num[NUM_W-1]};
        n_ge    = n_shift >= {2'b00, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= {i_num[NUM_W-2:0], 1'b0};
            r_rem <= n_ge ? (DEN_W+1)'(n_shift - {2'b00, i_den})
                          : (DEN_W+1)'(n_shift);
            r_den <= i_den;
            r_quo <= {i_quo[Q_W-2:0], n_ge};
        end
    end

    assign o_num = r_num;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
endmodule

// ===== dv/si_crossing_checker.sv =====
// ----------------------------------------------------------------------------
// si_crossing_checker
// Watches the segment word and crossing word channels of the segment
// intersection core, predicts each crossing and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module si_crossing_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    si_if               seg_ch,
    si_if               hit_ch,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked,
    output int unsigned o_hits
);
    localparam int FIELD_BITS = si_pkg::FIELD_BITS;
    localparam int OUT_BITS   = si_pkg::OUT_BITS;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_y;
        logic signed [OUT_BITS-1:0] cross_x;
    } t_crossing;

    t_crossing crossing_q[$];

    function automatic longint coord_of(logic [FIELD_BITS-1:0] f);
        longint v;
        v = longint'(signed'(f));
        if (COORD_BITS < FIELD_BITS) begin
            v = (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
        end
        return v;
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // start + num/den * delta in fixed point, quotient truncated, saturated
    function automatic logic [OUT_BITS-1:0] fixed_on(longint start, longint delta,
                                                     longint num, longint den);
        logic [127:0]        prod;
        logic [127:0]        quo;
        logic signed [127:0] v;
        prod = 128'(mag(num)) * 128'(mag(delta));
        quo  = (prod << FRAC_BITS) / 128'(mag(den));
        v    = 128'(start) <<< FRAC_BITS;
        if (sgn(num) * sgn(delta) * sgn(den) < 0) v = v - signed'(quo);
        else v = v + signed'(quo);
        if (v > 128'sd2147483647) v = 128'sd2147483647;
        if (v < -128'sd2147483648) v = -128'sd2147483648;
        return v[OUT_BITS-1:0];
    endfunction

    function automatic t_crossing predict_crossing(logic [8*FIELD_BITS-1:0] w);
        longint    c[8];
        longint    adx, ady, bdx, bdy, d1, d2, d3, d4;
        t_crossing r;
        for (int i = 0; i < 8; i++) c[i] = coord_of(w[i*FIELD_BITS +: FIELD_BITS]);
        adx = c[2] - c[0];
        ady = c[3] - c[1];
        bdx = c[6] - c[4];
        bdy = c[7] - c[5];
        d1  = bdx * (c[1] - c[5]) - bdy * (c[0] - c[4]);
        d2  = bdx * (c[3] - c[5]) - bdy * (c[2] - c[4]);
        d3  = adx * (c[5] - c[1]) - ady * (c[4] - c[0]);
        d4  = adx * (c[7] - c[1]) - ady * (c[6] - c[0]);
        r   = '0;
        if (sgn(d1) * sgn(d2) < 0 && sgn(d3) * sgn(d4) < 0) begin
            r.hit     = 1'b1;
            r.cross_x = fixed_on(c[0], adx, d1, d1 - d2);
            r.cross_y = fixed_on(c[1], ady, d1, d1 - d2);
        end
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    always @(posedge i_clk) begin
        t_crossing exp_w;
        t_crossing got_w;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_checked    <= 0;
            o_hits       <= 0;
        end else begin
            if (seg_ch.valid && seg_ch.ready) begin
                crossing_q.push_back(predict_crossing(seg_ch.data));
            end
            if (hit_ch.valid && hit_ch.ready) begin
                got_w = hit_ch.data;
                o_checked <= o_checked + 1;
                if (got_w.hit) o_hits <= o_hits + 1;
                if (crossing_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected crossing word %h", got_w);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = crossing_q.pop_front();
                    if (exp_w.hit !== got_w.hit || exp_w.cross_x !== got_w.cross_x ||
                        exp_w.cross_y !== got_w.cross_y) begin
                        if (o_fail_count < 10)
                            $display("ERROR: crossing mismatch exp hit=%0b x=%0d y=%0d,",
                                     exp_w.hit, exp_w.cross_x, exp_w.cross_y,
                                     " got hit=%0b x=%0d y=%0d",
                                     got_w.hit, got_w.cross_x, got_w.cross_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives segment pairs into the segment intersection core under changing
// idle patterns and a long output stall; the checker judges every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SEG_W       = 8 * si_pkg::FIELD_BITS;
    localparam int HIT_W       = 2 * si_pkg::OUT_BITS + 1;
    localparam int RAND_WORDS  = 400;
    localparam int DRAIN       = 120;      // well past the pipeline depth
    localparam int STALL_LEN   = 300;      // long output hold-off
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count, pending, checked, hits;
    int unsigned tx_idle, rx_idle;         // idle percentages
    logic        stall_req;
    logic        stall_done;
    int unsigned stall_left;
    int unsigned cycles = 0;

    si_if #(.WIDTH(SEG_W)) seg_ch ();
    si_if #(.WIDTH(HIT_W)) hit_ch ();

    segment_intersection_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_ch),
        .o_hit  (hit_ch)
    );

    si_crossing_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .seg_ch      (seg_ch),
        .hit_ch      (hit_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_hits      (hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random idling, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left   <= 0;
            stall_done   <= 1'b0;
            hit_ch.ready <= 1'b0;
        end else if (stall_req && !stall_done) begin
            stall_left   <= STALL_LEN;
            stall_done   <= 1'b1;
            hit_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            hit_ch.ready <= 1'b0;
        end else begin
            hit_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Offer one segment word, with random gaps before it; hold until taken.
    task automatic send_segments(logic [SEG_W-1:0] w);
        while ($urandom_range(99) < tx_idle) begin
            seg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= w;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [SEG_W-1:0] pack_pair(int ax1, int ay1, int ax2, int ay2,
                                                   int bx1, int by1, int bx2, int by2);
        return {16'(by2), 16'(bx2), 16'(by1), 16'(bx1),
                16'(ay2), 16'(ax2), 16'(ay1), 16'(ax1)};
    endfunction

    // Mostly full-range pairs (many cross); some on a tiny grid so collinear,
    // touching and degenerate cases turn up often.
    function automatic logic [SEG_W-1:0] random_pair();
        logic [SEG_W-1:0] w;
        int               c[8];
        if ($urandom_range(99) < 65) begin
            for (int i = 0; i < 4; i++) w[i*32 +: 32] = $urandom;
        end else begin
            for (int i = 0; i < 8; i++) c[i] = $urandom_range(8) - 4;
            w = pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
        return w;
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        seg_ch.valid = 1'b0;
        seg_ch.data  = '0;
        tx_idle      = 26;
        rx_idle      = 72;
        stall_req    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain crossing, extremes, and every kind of non-crossing.
        send_segments(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_segments(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_segments(pack_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_segments(pack_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        send_segments(pack_pair(0, 0, 3, 1, 0, 1, 2, 0));       // fractional point
        send_segments(pack_pair(0, 0, -7, 3, -1, 2, -5, -1));   // negative deltas
        send_segments(pack_pair(0, 0, 4, 4, 1, 1, 6, 6));       // collinear overlap
        send_segments(pack_pair(0, 0, 4, 4, 5, 5, 9, 9));       // collinear apart
        send_segments(pack_pair(3, 3, 3, 3, 0, 0, 6, 6));       // zero-length A
        send_segments(pack_pair(0, 6, 6, 0, 2, 2, 2, 2));       // zero-length B
        send_segments(pack_pair(0, 0, 4, 0, 2, 0, 2, 5));       // endpoint on other
        send_segments(pack_pair(0, 0, 4, 4, 4, 4, 8, 0));       // shared endpoint
        send_segments(pack_pair(0, 0, 2, 2, 5, 0, 5, 9));       // lines meet on B only
        send_segments(pack_pair(0, 0, 4, 0, 0, 1, 4, 1));       // parallel
        send_segments(pack_pair(0, 0, 1, 1, 5, 0, 3, 2));       // lines cross outside
        send_segments(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));       // all zero
        send_segments(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        send_segments(pack_pair(32767, 32767, -32768, -32768, -32768, -32767, 32767, 32766));
        send_segments(pack_pair(-32768, 1, 32767, -1, 1, 32767, -1, -32768));

        // Random, three idle patterns; long output stall in the last one.
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i == RAND_WORDS / 3) begin
                tx_idle = 72;
                rx_idle = 26;
            end else if (i == 2 * RAND_WORDS / 3) begin
                tx_idle   = 0;
                rx_idle   = 0;
                stall_req <= 1'b1;
            end
            send_segments(random_pair());
        end
        seg_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("checked %0d crossing words, %0d of them hits, over three idle patterns",
                 checked, hits);
        $display("and one %0d-cycle output stall; %0d mismatches", STALL_LEN, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
